[rtl/ptrm_pkg.sv]
// Shared types and constants for the pixel temporal running median block.
`timescale 1ns / 1ps
package ptrm_pkg;

  localparam int SAMPLE_W = 8;

  // Register indexes on the configuration port (byte address is 4x index)
  localparam logic [1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_WINDOW_LENGTH = 2'd2;

  localparam logic CMD_PRIME  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef struct packed {
    logic clear_en;
    logic accept;
    logic read;
    logic load;
    logic rank;
    logic write;
    logic out_load;
  } ptrm_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_prime;
    logic rank_last;
    logic out_free;
  } ptrm_status_t;

endpackage

[rtl/ptrm_ctrl.sv]
// Sequencer for the running median: memory clear, read, rank walk, write back, output.
`timescale 1ns / 1ps
module ptrm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  ptrm_pkg::ptrm_status_t status,
  output ptrm_pkg::ptrm_cmd_t    cmd
);
  import ptrm_pkg::*;

  typedef enum logic [2:0] {
    CLEAR, IDLE, READ, LOAD, RANK, WRITE, DONE
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLEAR;
    end else begin
      case (state)
        CLEAR: if (status.clear_done) state <= IDLE;
        IDLE:  if (s_tvalid) state <= READ;
        READ:  state <= LOAD;
        LOAD:  state <= status.is_prime ? WRITE : RANK;
        RANK:  if (status.rank_last) state <= WRITE;
        WRITE: state <= DONE;
        DONE:  if (status.out_free) state <= IDLE;
        default: state <= CLEAR;
      endcase
    end
  end

  assign s_tready = (state == IDLE);

  always_comb begin
    cmd          = '0;
    cmd.clear_en = (state == CLEAR);
    cmd.accept   = (state == IDLE) && s_tvalid;
    cmd.read     = (state == READ);
    cmd.load     = (state == LOAD);
    cmd.rank     = (state == RANK);
    cmd.write    = (state == WRITE);
    cmd.out_load = (state == DONE) && status.out_free;
  end

endmodule

[rtl/ptrm_datapath.sv]
// Pixel memory, frame position and slot tracking, rank unit and output word register.
`timescale 1ns / 1ps
module ptrm_datapath #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_WINDOW = 15
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ptrm_pkg::ptrm_cmd_t             cmd,
  output ptrm_pkg::ptrm_status_t          status,
  input  logic [6:0]                      frame_width,
  input  logic [6:0]                      frame_height,
  input  logic [3:0]                      window_length,
  input  logic                            in_command,
  input  logic [ptrm_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ptrm_pkg::SAMPLE_W-1:0]   m_tdata,
  output logic                            m_tlast
);
  import ptrm_pkg::*;

  localparam int NUM = MAX_WIDTH * MAX_HEIGHT;
  localparam int PB  = (NUM > 1) ? $clog2(NUM) : 1;
  localparam int TB  = $clog2(NUM + 1);
  localparam int WB  = $clog2(MAX_WIDTH + 1);
  localparam int HB  = $clog2(MAX_HEIGHT + 1);
  localparam int SB  = $clog2(MAX_WINDOW);
  localparam int NB  = $clog2(MAX_WINDOW + 1);
  localparam int ROW = MAX_WINDOW * SAMPLE_W;

  // Effective (clamped) frame and window sizes
  int w_i, h_i, n_i;
  logic [WB-1:0] w_eff;
  logic [HB-1:0] h_eff;
  logic [NB-1:0] win;
  logic [TB-1:0] total;

  always_comb begin
    w_i = int'(frame_width);
    if (w_i < 1) w_i = 1;
    if (w_i > MAX_WIDTH) w_i = MAX_WIDTH;
    h_i = int'(frame_height);
    if (h_i < 1) h_i = 1;
    if (h_i > MAX_HEIGHT) h_i = MAX_HEIGHT;
    n_i = int'(window_length);
    if (n_i < 5) n_i = 5;
    if (n_i > MAX_WINDOW) n_i = MAX_WINDOW;
  end

  assign w_eff = WB'(w_i);
  assign h_eff = HB'(h_i);
  assign win   = NB'(n_i);
  assign total = TB'(w_eff) * TB'(h_eff);

  // Frame position and shared oldest slot
  logic [PB-1:0] pos, pos_cur, pix;
  logic [TB-1:0] pos_inc;
  logic [SB-1:0] os, os_new, slot;
  logic [SB:0]   os_inc;
  logic          eof_q, prime_q;
  logic [SAMPLE_W-1:0] sample_q;

  assign pos_cur = (TB'(pos) >= total) ? '0 : pos;
  assign pos_inc = TB'(pos_cur) + TB'(1);
  assign os_inc  = (SB + 1)'(os) + (SB + 1)'(1);

  always_comb begin
    os_new = os;
    if (pos_cur == '0) begin
      os_new = (int'(os_inc) >= int'(win)) ? '0 : SB'(os_inc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      os  <= '0;
    end else if (cmd.accept) begin
      pos <= (pos_inc >= total) ? '0 : PB'(pos_inc);
      os  <= os_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix      <= pos_cur;
      slot     <= (int'(os_new) < int'(win)) ? os_new : '0;
      eof_q    <= (TB'(pos_cur) == total - TB'(1));
      prime_q  <= (in_command == CMD_PRIME);
      sample_q <= in_sample;
    end
  end

  // Pixel memory: one row of all window slots per pixel
  logic [ROW-1:0] mem [NUM];
  logic [ROW-1:0] rd_row, wr_row;
  logic [PB-1:0]  clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_en) begin
      clr_addr <= clr_addr + PB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      mem[clr_addr] <= '0;
    end else if (cmd.write) begin
      mem[pix] <= wr_row;
    end
    if (cmd.read) begin
      rd_row <= mem[pix];
    end
  end

  // Working copy of the pixel window
  logic [SAMPLE_W-1:0] work [MAX_WINDOW];
  logic [SB-1:0]       k;
  logic [NB-1:0]       rank;
  logic [SAMPLE_W-1:0] result;
  logic                found;
  logic [SAMPLE_W-1:0] cand;

  always_comb begin
    for (int j = 0; j < MAX_WINDOW; j++) begin
      wr_row[j*SAMPLE_W +: SAMPLE_W] = work[j];
    end
  end

  // Stable rank of the candidate: smaller values, plus equal ones at lower slots
  assign cand = work[k];
  always_comb begin
    rank = '0;
    for (int j = 0; j < MAX_WINDOW; j++) begin
      if (j < int'(win) &&
          (work[j] < cand || (work[j] == cand && j < int'(k)))) begin
        rank = rank + NB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int j = 0; j < MAX_WINDOW; j++) begin
        if (prime_q || j == int'(slot)) begin
          work[j] <= sample_q;
        end else begin
          work[j] <= rd_row[j*SAMPLE_W +: SAMPLE_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      k     <= '0;
    end else if (cmd.load) begin
      found <= prime_q;
      k     <= '0;
    end else if (cmd.rank) begin
      if (rank == (win >> 1)) found <= 1'b1;
      k <= k + SB'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result <= sample_q;
    end else if (cmd.rank && rank == (win >> 1)) begin
      result <= cand;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= result;
      m_tlast <= eof_q;
    end
  end

  always_comb begin
    status            = '0;
    status.clear_done = (clr_addr == PB'(NUM - 1));
    status.is_prime   = prime_q;
    status.rank_last  = (NB'(k) == win - NB'(1));
    status.out_free   = !m_tvalid || m_tready;
  end

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("output word overwritten before taken");

  a_rank_found: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> found)
    else $error("rank walk ended without a median");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (int'(slot) < int'(win)))
    else $error("replacement slot outside window");

endmodule

[rtl/pixel_temporal_running_median_core.sv]
// Top level: configuration registers, sequencer and datapath of the running median.
// An accepted word passes through read, load, one rank step per slot, write back and
// output, in that order; prime words skip the rank steps.
// A new word is taken only after the last one has been through the rank walk over the
// pixel's slots, one candidate per cycle, and has been loaded into the output register.
// Reset: synchronous; afterwards the pixel memory is cleared one row a cycle, all
// MAX_WIDTH*MAX_HEIGHT rows, and s_tready stays low until the clear is done.
`timescale 1ns / 1ps
module pixel_temporal_running_median_core #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64,
  parameter int MAX_WINDOW = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] sample
  input  logic        s_tuser,   // [0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] median
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ptrm_pkg::*;

  logic [6:0] frame_width, frame_height;
  logic [3:0] window_length;
  ptrm_cmd_t    cmd;
  ptrm_status_t status;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= 7'd64;
      frame_height  <= 7'd64;
      window_length <= 4'd5;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_FRAME_WIDTH:   frame_width   <= pwdata[6:0];
        REG_FRAME_HEIGHT:  frame_height  <= pwdata[6:0];
        REG_WINDOW_LENGTH: window_length <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FRAME_WIDTH:   prdata = {25'd0, frame_width};
      REG_FRAME_HEIGHT:  prdata = {25'd0, frame_height};
      REG_WINDOW_LENGTH: prdata = {28'd0, window_length};
      default:           prdata = '0;
    endcase
  end

  ptrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ptrm_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .frame_width   (frame_width),
    .frame_height  (frame_height),
    .window_length (window_length),
    .in_command    (s_tuser),
    .in_sample     (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast)
  );

endmodule

[tb/sv/ptrm_checker.sv]
// Checker for the running median core: predicts each result and compares it.
`timescale 1ns / 1ps
module ptrm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] sample
  input  logic        s_tuser,   // [0] command
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // [7:0] median
  input  logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fails,
  output int          pending
);
  import ptrm_pkg::*;

  typedef struct packed {
    logic [7:0] median;
    logic       eof;
  } median_word_t;

  localparam int NPIX = 64 * 64;
  localparam int NWIN = 15;

  logic [6:0]  fw_q, fh_q;
  logic [3:0]  wl_q;
  logic [7:0]  hist [NPIX][NWIN];
  int          oldest, pos;
  median_word_t want_q[$];

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic logic [7:0] window_rank(int pix, int n);
    logic [7:0] srt [NWIN];
    logic [7:0] t;
    for (int i = 0; i < n; i++) srt[i] = hist[pix][i];
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n - 1 - i; j++)
        if (srt[j] > srt[j+1]) begin
          t = srt[j]; srt[j] = srt[j+1]; srt[j+1] = t;
        end
    return srt[n/2];
  endfunction

  function automatic median_word_t predict_median(logic cmd, logic [7:0] smp);
    int w, h, win, total, pix, slot;
    median_word_t r;
    w = clip(fw_q, 1, 64);
    h = clip(fh_q, 1, 64);
    win = clip(wl_q, 5, NWIN);
    total = w * h;
    if (pos >= total) pos = 0;
    pix = pos;
    if (pix == 0) begin
      oldest++;
      if (oldest >= win) oldest = 0;
    end
    slot = (oldest < win) ? oldest : 0;
    if (cmd == CMD_PRIME) begin
      for (int i = 0; i < NWIN; i++) hist[pix][i] = smp;
      r.median = smp;
    end else begin
      hist[pix][slot] = smp;
      r.median = window_rank(pix, win);
    end
    r.eof = (pix == total - 1);
    pos = pix + 1;
    if (pos >= total) pos = 0;
    return r;
  endfunction

  assign pending = want_q.size();

  always @(posedge clk) begin
    median_word_t got, exp_w;
    if (rst) begin
      fw_q <= 7'd64; fh_q <= 7'd64; wl_q <= 4'd5;
      oldest = 0; pos = 0;
      for (int p = 0; p < NPIX; p++)
        for (int i = 0; i < NWIN; i++) hist[p][i] = 8'd0;
      want_q.delete();
      fails <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_FRAME_WIDTH:   fw_q <= pwdata[6:0];
          REG_FRAME_HEIGHT:  fh_q <= pwdata[6:0];
          REG_WINDOW_LENGTH: wl_q <= pwdata[3:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready)
        want_q.insert(want_q.size(), predict_median(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        got.median = m_tdata;
        got.eof = m_tlast;
        if (want_q.size() == 0) begin
          if (fails < 10) $display("unexpected word: median %0d last %0b", m_tdata, m_tlast);
          fails <= fails + 1;
        end else begin
          exp_w = want_q.pop_front();
          if (got !== exp_w) begin
            if (fails < 10)
              $display("mismatch: median exp %0d got %0d, last exp %0b got %0b",
                       exp_w.median, got.median, exp_w.eof, got.eof);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

[tb/sv/testbench.sv]
// Top of the running median testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
  import ptrm_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = CMD_PRIME;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fails, pending;
  bit          no_gaps = 1'b0;
  bit          hold_req = 1'b0;
  int          quiet = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pixel_temporal_running_median_core i_dut (.*);

  ptrm_checker i_chk (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (600) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          m_tready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_word(input logic cmd, input logic [7:0] smp);
    int n;
    n = pick_gap();
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= smp;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  task automatic drain();
    @(posedge clk);
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_frame(input int fw, input int fh, input int wl);
    reg_write(REG_FRAME_WIDTH, {$urandom} & 32'hFFFF_FF80 | fw);
    reg_write(REG_FRAME_HEIGHT, {$urandom} & 32'hFFFF_FF80 | fh);
    reg_write(REG_WINDOW_LENGTH, {$urandom} & 32'hFFFF_FFF0 | wl);
  endtask

  // mostly primes in the first frame, then mostly updates with random content
  task automatic run_frames(input int npix, input int count, input bit squeeze);
    logic cmd;
    logic [7:0] smp;
    for (int k = 0; k < count; k++) begin
      if (k < npix) cmd = ($urandom_range(0, 9) != 0) ? CMD_PRIME : CMD_UPDATE;
      else cmd = ($urandom_range(0, 9) == 0) ? CMD_PRIME : CMD_UPDATE;
      case ($urandom_range(0, 7))
        0: smp = 8'd0;
        1: smp = 8'd255;
        2: smp = 8'd120 + 8'($urandom_range(0, 15));
        default: smp = 8'($urandom);
      endcase
      if (squeeze && k == count / 2) hold_req = 1'b1;
      send_word(cmd, smp);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // reset frame size of 64 by 64 pixels; only a few words are sent
    send_word(CMD_PRIME, 8'd0);
    send_word(CMD_PRIME, 8'd255);
    send_word(CMD_UPDATE, 8'd255);
    send_word(CMD_UPDATE, 8'd0);
    drain();
    // single pixel frame: every word is last of frame, slot advances every word
    set_frame(1, 1, 5);
    send_word(CMD_PRIME, 8'd255);
    send_word(CMD_UPDATE, 8'd0);
    send_word(CMD_UPDATE, 8'd0);
    send_word(CMD_UPDATE, 8'd0);
    send_word(CMD_UPDATE, 8'd7);
    send_word(CMD_UPDATE, 8'd255);
    send_word(CMD_UPDATE, 8'd255);
    send_word(CMD_PRIME, 8'd0);
    send_word(CMD_UPDATE, 8'd200);
    drain();
    // zero size counts as one, out-of-range window saturates; window grows to 15
    set_frame(0, 0, 0);
    send_word(CMD_UPDATE, 8'd90);
    send_word(CMD_UPDATE, 8'd91);
    drain();
    set_frame(127, 1, 15);
    for (int k = 0; k < 6; k++) send_word(CMD_UPDATE, 8'd255);
    drain();

    set_frame(3, 2, 7);
    run_frames(6, 200, 1'b0);
    drain();
    no_gaps = 1'b1;
    set_frame(2, 2, 15);
    run_frames(4, 200, 1'b1);
    drain();
    no_gaps = 1'b0;
    set_frame(5, 1, 9);
    run_frames(5, 150, 1'b0);
    drain();
    // shrink mid-frame and window
    set_frame(1, 3, 4);
    run_frames(3, 150, 1'b0);
    drain();
    set_frame(64, 1, 12);
    run_frames(64, 250, 1'b1);
    drain();
    set_frame(1, 64, 6);
    run_frames(64, 250, 1'b0);
    drain();
    set_frame(4, 4, 5);
    run_frames(16, 200, 1'b0);
    drain();
    set_frame(2, 3, 11);
    run_frames(6, 150, 1'b0);
    drain();
    set_frame(7, 127, 15);
    run_frames(448, 200, 1'b0);
    drain();

    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
